// ===== rtl/base64_stream_encoder_assert.svh =====
// Assertion macros used by the encoder back end (b64e_back).
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("encoder assertion failed");

// The consequent holds in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`endif

// ===== rtl/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

  localparam int unsigned GrpQDepth = 2;
  localparam int unsigned GrpQPtrW  = $clog2(GrpQDepth);
  localparam int unsigned GrpQCntW  = $clog2(GrpQDepth + 1);

  localparam logic [7:0] PadChar    = 8'h3D;
  localparam logic [7:0] AsciiUpper = 8'h41;
  localparam logic [7:0] AsciiLower = 8'h61;
  localparam logic [7:0] AsciiDigit = 8'h30;
  localparam logic [7:0] AsciiPlus  = 8'h2B;
  localparam logic [7:0] AsciiSlash = 8'h2F;
  localparam logic [15:0] CapacityReset = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        out_last;
    logic        out_error;
    logic [15:0] out_count;
  } out_t;

  // One group of up to three bytes; unused bytes are zero.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nheld;
    logic            last;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] ve;
    ve = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(AsciiUpper + ve);
    end else if (v < 6'd52) begin
      return 8'(AsciiLower + ve - 8'd26);
    end else if (v < 6'd62) begin
      return 8'(AsciiDigit + ve - 8'd52);
    end else if (v == 6'd62) begin
      return AsciiPlus;
    end else begin
      return AsciiSlash;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64e_front.sv =====
`default_nettype none

module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  b64e_pkg::in_t    in_data_i,
  input  b64e_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output b64e_pkg::grp_t   push_grp_o
);
  import b64e_pkg::*;

  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic       accept;
  logic       complete;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign complete   = (held_cnt_q == 2'd2) || in_data_i.last_byte;
  assign push_o     = accept && complete;

  always_comb begin
    push_grp_o.nheld = held_cnt_q;
    push_grp_o.last  = in_data_i.last_byte;
    unique case (held_cnt_q)
      2'd0:    push_grp_o.bytes = {8'h00, 8'h00, in_data_i.data_byte};
      2'd1:    push_grp_o.bytes = {8'h00, in_data_i.data_byte, held0_q};
      default: push_grp_o.bytes = {in_data_i.data_byte, held1_q, held0_q};
    endcase
  end

  always_comb begin
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    if (accept) begin
      if (complete) begin
        held_cnt_d = 2'd0;
      end else begin
        if (held_cnt_q == 2'd0) begin
          held0_d = in_data_i.data_byte;
        end else begin
          held1_d = in_data_i.data_byte;
        end
        held_cnt_d = 2'(held_cnt_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
`default_nettype none

module b64e_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::grp_t    push_grp_i,
  input  logic              pop_i,
  output b64e_pkg::grp_t    pop_grp_o,
  output b64e_pkg::q_stat_t stat_o
);
  import b64e_pkg::*;

  grp_t                slot_q [GrpQDepth];
  logic [GrpQPtrW-1:0] wr_ptr_q;
  logic [GrpQPtrW-1:0] rd_ptr_q;
  logic [GrpQCntW-1:0] cnt_q;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = (cnt_q == GrpQCntW'(GrpQDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_grp_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= GrpQPtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= GrpQPtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= GrpQCntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= GrpQCntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_grp_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module b64e_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  b64e_pkg::grp_t    grp_i,
  input  b64e_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output b64e_pkg::out_t    out_data_o
);
  import b64e_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [15:0]            cap_q;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [1:0]             k_q, k_d;
  logic                   discard_q, discard_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;
  logic                   can_out;
  logic                   step;
  logic                   over;
  logic                   load;
  logic [5:0]             sext;
  logic [7:0]             ch;
  logic [CmpW-1:0]        count_ext;
  logic [CmpW-1:0]        inc_ext;

  assign can_out   = !out_valid_q || !out_stall_i;
  assign step      = !q_stat_i.empty && can_out;
  assign count_inc = COUNT_WIDTH'(count_q + 1'b1);
  assign count_ext = CmpW'(count_q);
  assign inc_ext   = CmpW'(count_inc);
  assign over      = count_ext >= CmpW'(cap_q);

  always_comb begin
    unique case (k_q)
      2'd0:    sext = grp_i.bytes[0][7:2];
      2'd1:    sext = {grp_i.bytes[0][1:0], grp_i.bytes[1][7:4]};
      2'd2:    sext = {grp_i.bytes[1][3:0], grp_i.bytes[2][7:6]};
      default: sext = grp_i.bytes[2][5:0];
    endcase
    ch = (k_q <= 2'(grp_i.nheld + 2'd1)) ? b64_char(sext) : PadChar;
  end

  always_comb begin
    count_d   = count_q;
    k_d       = k_q;
    discard_d = discard_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    out_d     = out_q;
    if (step) begin
      priority if (discard_q) begin
        pop_o = 1'b1;
        if (grp_i.last) begin
          discard_d = 1'b0;
        end
      end else if (over) begin
        pop_o           = 1'b1;
        load            = 1'b1;
        out_d.out_char  = 8'h00;
        out_d.out_last  = 1'b1;
        out_d.out_error = 1'b1;
        out_d.out_count = count_ext[15:0];
        count_d         = '0;
        k_d             = 2'd0;
        discard_d       = !grp_i.last;
      end else begin
        load            = 1'b1;
        out_d.out_char  = ch;
        out_d.out_last  = grp_i.last && (k_q == 2'd3);
        out_d.out_error = 1'b0;
        out_d.out_count = inc_ext[15:0];
        count_d         = (grp_i.last && (k_q == 2'd3)) ? '0 : count_inc;
        if (k_q == 2'd3) begin
          pop_o = 1'b1;
        end
        k_d = 2'(k_q + 2'd1);
      end
    end
    out_valid_d = can_out ? load : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapacityReset;
      count_q     <= '0;
      k_q         <= 2'd0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      k_q         <= k_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `B64E_ASSERT_SAME(a_err_is_final, out_valid_q && out_q.out_error, out_q.out_last && out_q.out_char == 8'h00)
  `B64E_ASSERT_SAME(a_mid_group_not_discarding, k_q != 2'd0, !discard_q)
  `B64E_ASSERT_NEXT(a_final_clears_count, load && out_d.out_last, count_q == '0 && k_q == 2'd0)

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// The byte that completes a group is written into the group queue; the group's first character is
// then registered into the output register, and the other characters of the group follow it.
// Throughput: one byte accepted per cycle while the group queue has room; one character
// leaves per cycle while out_stall_i is low; a steady stream gives four chars per three bytes.
// Reset (rst_ni low, asynchronous) empties the queue, clears the held-byte count, the output
// count and the discard flag, and sets the output capacity to 65535.
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  b64e_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output b64e_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);
  import b64e_pkg::*;

  q_stat_t q_stat;
  logic    push;
  grp_t    push_grp;
  logic    pop;
  grp_t    pop_grp;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  b64e_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .pop_i      (pop),
    .pop_grp_o  (pop_grp),
    .stat_o     (q_stat)
  );

  b64e_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .grp_i       (pop_grp),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
